[design/fdl_pkg.sv]
package fdl_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [5:0]         edge_first;
    logic [5:0]         edge_second;
    logic [31:0]        edge_weight;
  } fdl_in_t;

  typedef struct packed {
    logic [5:0]         out_node;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last;
  } fdl_out_t;

  typedef struct packed {
    logic go;
    logic sqrt;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_NODE  = 2'd1;
  localparam logic [1:0] REQ_EDGE  = 2'd2;
  localparam logic [1:0] REQ_RUN   = 2'd3;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_ITER    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SPRING  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GAIN    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAXDIST = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAXMOVE = 3'd4;

  localparam logic [9:0]  RST_ITER    = 10'd100;
  localparam logic [31:0] RST_SPRING  = 32'd131072;
  localparam logic [31:0] RST_GAIN    = 32'd655;
  localparam logic [31:0] RST_MAXDIST = 32'd6553600;
  localparam logic [31:0] RST_MAXMOVE = 32'd32768;

  localparam logic [63:0] NEAR_SQ   = 64'd42949673;
  localparam logic [31:0] NUDGE     = 32'd6554;
  localparam logic [63:0] NUDGE_SQ2 = 64'd85909832;
  localparam logic [31:0] LN2_Q16   = 32'd45426;
  localparam logic [31:0] ONE_Q16   = 32'd65536;

endpackage

[design/fdl_mul.sv]
module fdl_mul
  import fdl_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

[design/fdl_divsqrt.sv]
module fdl_divsqrt
  import fdl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ds_ctrl_t    ctrl,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output ds_stat_t    stat,
  output logic [63:0] res
);

  logic        run;
  logic        sq;
  logic [6:0]  cnt;
  logic [64:0] rem;
  logic [63:0] quo;
  logic [63:0] bitm;
  logic [63:0] dv;
  logic        done;
  logic [64:0] sh;
  logic [63:0] trial;

  assign sh    = {rem[63:0], quo[63]};
  assign trial = quo + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (!run && ctrl.go) begin
        run <= 1'b1;
        cnt <= ctrl.sqrt ? 7'd32 : 7'd64;
      end else if (run) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!run && ctrl.go) begin
      sq <= ctrl.sqrt;
      dv <= den;
      if (ctrl.sqrt) begin
        rem  <= {1'b0, num};
        quo  <= 64'd0;
        bitm <= 64'd1 << 62;
      end else begin
        rem <= 65'd0;
        quo <= num;
      end
    end else if (run) begin
      if (sq) begin
        if (rem[63:0] >= trial) begin
          rem <= {1'b0, rem[63:0] - trial};
          quo <= (quo >> 1) + bitm;
        end else begin
          quo <= quo >> 1;
        end
        bitm <= bitm >> 2;
      end else begin
        if (sh >= {1'b0, dv}) begin
          rem <= sh - {1'b0, dv};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= sh;
          quo <= {quo[62:0], 1'b0};
        end
      end
    end
  end

  assign res       = quo;
  assign stat.busy = run;
  assign stat.done = done;

endmodule

[design/force_directed_layout.sv]
// a clear, node or edge transfer is taken while idle, and the next can follow at once
// a run visits every node pair and every edge in each iteration, its time dominated by the
// shared divider and square root unit, then it sends one result per node
// results leave on strobe and cannot be stalled
// synchronous reset loads the register defaults and empties the node and edge stores
module force_directed_layout
  import fdl_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fdl_in_t           cmd,
  output logic              strobe,
  output fdl_out_t          result,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int NAW  = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int EAW  = $clog2(MAX_EDGES);
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int CMPW = (NCW > 6) ? NCW : 6;

  localparam logic [5:0] S_IDLE = 6'd0,  S_ITER = 6'd1,  S_K2 = 6'd2,    S_PAIR = 6'd3;
  localparam logic [5:0] S_RDA = 6'd4,   S_RDB = 6'd5,   S_DIF = 6'd6,   S_SQX = 6'd7;
  localparam logic [5:0] S_SQY = 6'd8,   S_SUM = 6'd9,   S_SQRT = 6'd10, S_RCHK = 6'd11;
  localparam logic [5:0] S_RDIV = 6'd12, S_PJX = 6'd13,  S_PJXD = 6'd14, S_PJXW = 6'd15;
  localparam logic [5:0] S_PJY = 6'd16,  S_PJYD = 6'd17, S_PJYW = 6'd18, S_FURD = 6'd19;
  localparam logic [5:0] S_FUWR = 6'd20, S_EDGE = 6'd21, S_ERD = 6'd22,  S_ELAT = 6'd23;
  localparam logic [5:0] S_ADC = 6'd24,  S_AD2 = 6'd25,  S_ADIV = 6'd26, S_LGSQ = 6'd27;
  localparam logic [5:0] S_LGS2 = 6'd28, S_LGF = 6'd29,  S_LGF2 = 6'd30, S_AMG = 6'd31;
  localparam logic [5:0] S_AMG2 = 6'd32, S_MVN = 6'd33,  S_MVRD = 6'd34, S_MVX = 6'd35;
  localparam logic [5:0] S_MVX2 = 6'd36, S_MVY = 6'd37,  S_MVY2 = 6'd38, S_OUTN = 6'd39;
  localparam logic [5:0] S_OUTE = 6'd40;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [34:0] b);
    logic signed [35:0] s;
    s = 36'(a) + 36'(b);
    if (s > 36'sh07FFFFFFF) sat_add = 32'sh7FFFFFFF;
    else if (s < -36'sh080000000) sat_add = 32'sh80000000;
    else sat_add = s[31:0];
  endfunction

  function automatic logic signed [31:0] signed_sat(input logic [63:0] m, input logic neg);
    if (neg) signed_sat = (m >= 64'h80000000) ? 32'sh80000000 : -$signed(m[31:0]);
    else signed_sat = (m > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(m[31:0]);
  endfunction

  function automatic logic [31:0] lim_mag(input logic [63:0] m, input logic neg);
    if (neg) lim_mag = (m >= 64'h80000000) ? 32'h80000000 : m[31:0];
    else lim_mag = (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 32'(-v) : v[31:0];
  endfunction

  function automatic logic [4:0] msb_of(input logic [31:0] w);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) r = 5'(i);
    end
    msb_of = r;
  endfunction

  // configuration
  logic [9:0]  iter_cnt;
  logic [31:0] k_len, step_c, max_dist, max_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cnt <= RST_ITER;
      k_len    <= RST_SPRING;
      step_c   <= RST_GAIN;
      max_dist <= RST_MAXDIST;
      max_mv   <= RST_MAXMOVE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ITER:    iter_cnt <= cfg_data[9:0];
        REG_SPRING:  k_len    <= cfg_data;
        REG_GAIN:    step_c   <= cfg_data;
        REG_MAXDIST: max_dist <= cfg_data;
        REG_MAXMOVE: max_mv   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer registers
  logic [5:0]         state;
  logic [NCW-1:0]     n, a, b;
  logic [ECW-1:0]     ne, e;
  logic [9:0]         iters_left;
  logic [NAW-1:0]     ai, aj;
  logic               att;
  logic signed [31:0] xa, ya;
  logic signed [32:0] dx, dy;
  logic [31:0]        ux, uy;
  logic               halved;
  logic [63:0]        sqx, k2;
  logic [33:0]        d, den;
  logic [31:0]        f_mag, dc, lx, wreg, amag;
  logic               f_neg, att_neg;
  logic signed [31:0] cx, cy;
  logic [2:0]         op;
  logic [4:0]         msb;
  logic [15:0]        frac;
  logic [3:0]         lstep;
  logic [19:0]        gain;

  // memories
  logic signed [31:0] xmem [MAX_NODES];
  logic signed [31:0] ymem [MAX_NODES];
  logic signed [31:0] fxmem [MAX_NODES];
  logic signed [31:0] fymem [MAX_NODES];
  logic [NAW-1:0]     srcmem [MAX_EDGES];
  logic [NAW-1:0]     dstmem [MAX_EDGES];
  logic [31:0]        wmem [MAX_EDGES];

  logic               pos_re, px_we, py_we;
  logic [NAW-1:0]     pos_ra, pos_wa;
  logic signed [31:0] px_wd, py_wd, xrd, yrd;
  logic               f_re, fx_we, fy_we;
  logic [NAW-1:0]     f_ra, f_wa;
  logic signed [31:0] f_wd, fxrd, fyrd;
  logic               e_re, e_we;
  logic [EAW-1:0]     e_ra, e_wa;
  logic [NAW-1:0]     src_rd, dst_rd;
  logic [31:0]        w_rd;

  always_ff @(posedge clk) begin
    if (px_we) xmem[pos_wa] <= px_wd;
    if (py_we) ymem[pos_wa] <= py_wd;
    if (pos_re) begin
      xrd <= xmem[pos_ra];
      yrd <= ymem[pos_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fx_we) fxmem[f_wa] <= f_wd;
    if (fy_we) fymem[f_wa] <= f_wd;
    if (f_re) begin
      fxrd <= fxmem[f_ra];
      fyrd <= fymem[f_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      srcmem[e_wa] <= NAW'(cmd.edge_first);
      dstmem[e_wa] <= NAW'(cmd.edge_second);
      wmem[e_wa]   <= cmd.edge_weight;
    end
    if (e_re) begin
      src_rd <= srcmem[e_ra];
      dst_rd <= dstmem[e_ra];
      w_rd   <= wmem[e_ra];
    end
  end

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  ds_ctrl_t    ds_ctrl;
  ds_stat_t    ds_stat;
  logic [63:0] ds_num, ds_den, ds_res;

  fdl_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  fdl_divsqrt u_ds (
    .clk(clk), .rst(rst), .ctrl(ds_ctrl), .num(ds_num), .den(ds_den),
    .stat(ds_stat), .res(ds_res)
  );

  // shared combinational terms
  logic               accept;
  logic [31:0]        kq, ha, hb, dcv, lxn;
  logic [63:0]        d2_sum, sv, diff;
  logic               near, d_in;
  logic signed [32:0] dxw, dyw;
  logic               node_ok, edge_ok, fu_last;
  logic signed [31:0] fu_c, fu_cur, fu_new;
  logic signed [34:0] fu_c35, fu_add;
  logic [47:0]        mv_raw;
  logic [31:0]        mv_m;
  logic signed [34:0] mv_add;
  logic signed [31:0] mv_new;
  logic [NAW-1:0]     fu_node;

  assign accept  = start && !busy;
  assign kq      = (k_len == 32'd0) ? 32'd1 : k_len;
  assign ha      = halved ? (ux >> 1) : ux;
  assign hb      = halved ? (uy >> 1) : uy;
  assign d2_sum  = sqx + prod;
  assign near    = !halved && (d2_sum < NEAR_SQ);
  assign sv      = near ? NUDGE_SQ2 : d2_sum;
  assign d_in    = d < {2'b00, max_dist};
  assign dcv     = (d > {2'b00, max_dist}) ? max_dist
                 : ((d == 34'd0) ? 32'd1 : d[31:0]);
  assign diff    = (prod < k2) ? (k2 - prod) : (prod - k2);
  assign dxw     = 33'(xrd) - 33'(xa);
  assign dyw     = 33'(yrd) - 33'(ya);
  assign lxn     = (msb_of(wreg) >= 5'd30) ? (wreg >> (msb_of(wreg) - 5'd30))
                                           : (wreg << (5'd30 - msb_of(wreg)));
  assign node_ok = n < NCW'(MAX_NODES);
  assign edge_ok = (ne < ECW'(MAX_EDGES)) && (CMPW'(cmd.edge_first) < CMPW'(n))
                && (CMPW'(cmd.edge_second) < CMPW'(n));
  assign fu_node = op[1] ? ai : aj;
  assign fu_c    = op[0] ? cy : cx;
  assign fu_c35  = 35'(fu_c);
  assign fu_add  = !op[2] ? (op[1] ? -fu_c35 : fu_c35)
                          : (op[1] ? (fu_c35 <<< 1) : -(fu_c35 <<< 1));
  assign fu_cur  = op[0] ? fyrd : fxrd;
  assign fu_new  = sat_add(fu_cur, fu_add);
  assign fu_last = att ? (op == 3'd7) : (op == 3'd3);
  assign mv_raw  = prod[63:16];
  assign mv_m    = (mv_raw > 48'(max_mv)) ? max_mv : mv_raw[31:0];
  assign mv_add  = (state == S_MVX2 ? fxrd[31] : fyrd[31]) ? -$signed({3'b000, mv_m})
                                                           : $signed({3'b000, mv_m});
  assign mv_new  = sat_add(state == S_MVX2 ? xrd : yrd, mv_add);

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_ITER: begin mul_a = kq; mul_b = kq; end
      S_SQX:  begin mul_a = ha; mul_b = ha; end
      S_SQY:  begin mul_a = hb; mul_b = hb; end
      S_PJX:  begin mul_a = f_mag; mul_b = ux; end
      S_PJY:  begin mul_a = f_mag; mul_b = uy; end
      S_ADC:  begin mul_a = dcv; mul_b = dcv; end
      S_LGSQ: begin mul_a = lx; mul_b = lx; end
      S_LGF:  begin mul_a = 32'({4'(msb - 5'd16), frac}); mul_b = LN2_Q16; end
      S_AMG:  begin mul_a = amag; mul_b = 32'(gain); end
      S_MVX:  begin mul_a = mag32(fxrd); mul_b = step_c; end
      S_MVY:  begin mul_a = mag32(fyrd); mul_b = step_c; end
      default: ;
    endcase
  end

  always_comb begin
    ds_ctrl = '0;
    ds_num  = 64'd0;
    ds_den  = 64'd1;
    case (state)
      S_SUM: begin
        ds_ctrl.go = 1'b1; ds_ctrl.sqrt = 1'b1; ds_num = sv;
      end
      S_RCHK: begin
        ds_ctrl.go = d_in; ds_num = k2;
        ds_den = (d == 34'd0) ? 64'd1 : 64'(d);
      end
      S_PJXD, S_PJYD: begin
        ds_ctrl.go = 1'b1; ds_num = prod;
        ds_den = (den == 34'd0) ? 64'd1 : 64'(den);
      end
      S_AD2: begin
        ds_ctrl.go = 1'b1; ds_num = diff; ds_den = 64'(kq);
      end
      default: ;
    endcase
  end

  always_comb begin
    pos_re = 1'b0; pos_ra = a[NAW-1:0];
    px_we = 1'b0; py_we = 1'b0; pos_wa = a[NAW-1:0];
    px_wd = mv_new; py_wd = mv_new;
    f_re = 1'b0; f_ra = a[NAW-1:0];
    fx_we = 1'b0; fy_we = 1'b0; f_wa = a[NAW-1:0]; f_wd = 32'sd0;
    e_re = 1'b0; e_ra = e[EAW-1:0];
    e_we = 1'b0; e_wa = ne[EAW-1:0];
    case (state)
      S_IDLE: begin
        if (accept && cmd.req_type == REQ_NODE && node_ok) begin
          px_we = 1'b1; py_we = 1'b1; pos_wa = n[NAW-1:0];
          px_wd = cmd.pos_x; py_wd = cmd.pos_y;
          fx_we = 1'b1; fy_we = 1'b1; f_wa = n[NAW-1:0];
        end
        if (accept && cmd.req_type == REQ_EDGE && edge_ok) e_we = 1'b1;
      end
      S_RDA: begin pos_re = 1'b1; pos_ra = ai; end
      S_RDB: begin pos_re = 1'b1; pos_ra = aj; end
      S_FURD: begin f_re = 1'b1; f_ra = fu_node; end
      S_FUWR: begin
        f_wa = fu_node; f_wd = fu_new;
        fx_we = !op[0]; fy_we = op[0];
      end
      S_ERD: e_re = 1'b1;
      S_MVRD: begin pos_re = 1'b1; f_re = 1'b1; end
      S_MVX2: px_we = 1'b1;
      S_MVY2: begin py_we = 1'b1; fx_we = 1'b1; fy_we = 1'b1; end
      S_OUTN: pos_re = a < n;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      n      <= '0;
      ne     <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.req_type)
              REQ_CLEAR: begin n <= '0; ne <= '0; end
              REQ_NODE:  if (node_ok) n <= n + NCW'(1);
              REQ_EDGE:  if (edge_ok) ne <= ne + ECW'(1);
              REQ_RUN: begin iters_left <= iter_cnt; state <= S_ITER; end
              default: ;
            endcase
          end
        end
        S_ITER: begin
          if (iters_left == 10'd0) begin
            a <= '0; state <= S_OUTN;
          end else begin
            state <= S_K2;
          end
        end
        S_K2: begin
          k2 <= prod; a <= '0; b <= NCW'(1); e <= '0; state <= S_PAIR;
        end
        S_PAIR: begin
          if (b < n) begin
            ai <= a[NAW-1:0]; aj <= b[NAW-1:0]; att <= 1'b0; state <= S_RDA;
          end else if ((NCW+1)'(a) + (NCW+1)'(2) < (NCW+1)'(n)) begin
            a <= a + NCW'(1); b <= a + NCW'(2);
          end else begin
            state <= S_EDGE;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin xa <= xrd; ya <= yrd; state <= S_DIF; end
        S_DIF: begin
          dx <= dxw; dy <= dyw; ux <= mag33(dxw); uy <= mag33(dyw);
          halved <= mag33(dxw)[31] || mag33(dyw)[31];
          state <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin sqx <= prod; state <= S_SUM; end
        S_SUM: begin
          if (near) begin
            dx <= 33'(NUDGE); dy <= 33'(NUDGE); ux <= NUDGE; uy <= NUDGE;
          end
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (ds_stat.done) begin
            d <= halved ? {ds_res[32:0], 1'b0} : {1'b0, ds_res[32:0]};
            state <= att ? S_ADC : S_RCHK;
          end
        end
        S_RCHK: begin
          if (d_in) state <= S_RDIV;
          else begin b <= b + NCW'(1); state <= S_PAIR; end
        end
        S_RDIV: begin
          if (ds_stat.done) begin
            f_mag <= lim_mag(ds_res, 1'b0); f_neg <= 1'b0; den <= d; state <= S_PJX;
          end
        end
        S_PJX: state <= S_PJXD;
        S_PJXD: state <= S_PJXW;
        S_PJXW: begin
          if (ds_stat.done) begin
            cx <= signed_sat(ds_res, f_neg ^ dx[32]); state <= S_PJY;
          end
        end
        S_PJY: state <= S_PJYD;
        S_PJYD: state <= S_PJYW;
        S_PJYW: begin
          if (ds_stat.done) begin
            cy <= signed_sat(ds_res, f_neg ^ dy[32]); op <= 3'd0; state <= S_FURD;
          end
        end
        S_FURD: state <= S_FUWR;
        S_FUWR: begin
          op <= op + 3'd1;
          if (!fu_last) state <= S_FURD;
          else if (att) begin e <= e + ECW'(1); state <= S_EDGE; end
          else begin b <= b + NCW'(1); state <= S_PAIR; end
        end
        S_EDGE: begin
          if (e < ne) state <= S_ERD;
          else begin a <= '0; state <= S_MVN; end
        end
        S_ERD: state <= S_ELAT;
        S_ELAT: begin
          ai <= src_rd; aj <= dst_rd; wreg <= w_rd; att <= 1'b1; state <= S_RDA;
        end
        S_ADC: begin dc <= dcv; state <= S_AD2; end
        S_AD2: begin att_neg <= prod < k2; state <= S_ADIV; end
        S_ADIV: begin
          if (ds_stat.done) begin
            amag <= lim_mag(ds_res, att_neg);
            if (wreg <= ONE_Q16) begin
              gain <= 20'(ONE_Q16); state <= S_AMG;
            end else begin
              msb <= msb_of(wreg); lx <= lxn; frac <= '0; lstep <= 4'd15;
              state <= S_LGSQ;
            end
          end
        end
        S_LGSQ: state <= S_LGS2;
        S_LGS2: begin
          if (prod[63:30] >= 34'h080000000) begin
            lx <= prod[62:31]; frac[lstep] <= 1'b1;
          end else begin
            lx <= prod[61:30];
          end
          if (lstep == 4'd0) state <= S_LGF;
          else begin lstep <= lstep - 4'd1; state <= S_LGSQ; end
        end
        S_LGF: state <= S_LGF2;
        S_LGF2: begin gain <= prod[36:17] + 20'(ONE_Q16); state <= S_AMG; end
        S_AMG: state <= S_AMG2;
        S_AMG2: begin
          f_mag <= lim_mag(64'(prod[63:16]), att_neg);
          f_neg <= att_neg && (lim_mag(64'(prod[63:16]), att_neg) != 32'd0);
          den <= {2'b00, dc};
          state <= S_PJX;
        end
        S_MVN: begin
          if (a < n) state <= S_MVRD;
          else begin iters_left <= iters_left - 10'd1; state <= S_ITER; end
        end
        S_MVRD: state <= S_MVX;
        S_MVX: state <= S_MVX2;
        S_MVX2: state <= S_MVY;
        S_MVY: state <= S_MVY2;
        S_MVY2: begin a <= a + NCW'(1); state <= S_MVN; end
        S_OUTN: state <= (a < n) ? S_OUTE : S_IDLE;
        S_OUTE: begin
          strobe <= 1'b1;
          a <= a + NCW'(1);
          state <= S_OUTN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUTE) begin
      result.out_node <= 6'(a);
      result.out_x    <= xrd;
      result.out_y    <= yrd;
      result.last     <= (a + NCW'(1)) == n;
    end
  end

  assign busy = state != S_IDLE;

`ifndef ASSERT_OFF
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == S_OUTE)
    else $error("result strobe without output step");
  a_node_cnt: assert property (@(posedge clk) disable iff (rst)
    n <= NCW'(MAX_NODES))
    else $error("node count beyond store");
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ds_stat.busy)
    else $error("divider active while idle");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("transfer after last");
`endif

endmodule
